/* sv/utf8_stream_decoder_defines.svh */
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/u8sd_pkg.sv */
package u8sd_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;

    // Code point 0xFFFD, sent in place of malformed input.
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // High-bit tags that classify a raw byte.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Number of continuation bytes that each lead byte asks for.
    localparam logic [1:0] NEED_ONE   = 2'd1;
    localparam logic [1:0] NEED_TWO   = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // Sequence state carried from one byte to the next.
    typedef struct packed {
        logic [CP_W-1:0] partial;
        logic [1:0]      need;
        logic [1:0]      buffered;
    } state_t;

    // Results caused by one byte: a run of replacements, then an optional tail result.
    typedef struct packed {
        logic [1:0]      rep_count;
        logic            tail_vld;
        logic [CP_W-1:0] tail_cp;
        logic            tail_bad;
        logic            end_flag;
    } job_t;

endpackage

/* sv/u8sd_byte_if.sv */
interface u8sd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8sd_pkg::BYTE_W-1:0]   data_byte;
    logic                          final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* sv/u8sd_cp_if.sv */
interface u8sd_cp_if;
    logic                        valid;
    logic                        ready;
    logic [u8sd_pkg::CP_W-1:0]   code_point;
    logic                        malformed;
    logic                        string_end;
    logic                        run_last;

    modport source (output valid, output code_point, output malformed,
                    output string_end, output run_last, input ready);
    modport sink   (input valid, input code_point, input malformed,
                    input string_end, input run_last, output ready);
endinterface

/* sv/u8sd_decode.sv */
module u8sd_decode (
    input  u8sd_pkg::state_t                st,
    input  logic [u8sd_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            final_byte,
    output u8sd_pkg::state_t                st_next,
    output u8sd_pkg::job_t                  job
);

    logic [u8sd_pkg::CP_W-1:0] cont_pv;
    logic [1:0]                need_dec;
    logic [1:0]                buf_inc;
    logic                      is_cont;
    logic                      fresh;
    logic                      nul_hit;

    assign is_cont  = (data_byte[7:6] == u8sd_pkg::CONT_TAG);
    assign cont_pv  = {st.partial[u8sd_pkg::CP_W-7:0], data_byte[5:0]};
    assign need_dec = st.need - 2'd1;
    assign buf_inc  = st.buffered + 2'd1;

    always_comb
    begin
        st_next      = st;
        job          = '0;
        fresh        = 1'b0;
        nul_hit      = 1'b0;

        // Continue or break a pending sequence
        if (st.need != 2'd0)
        begin
            if (is_cont)
            begin
                if (need_dec == 2'd0)
                begin
                    job.tail_vld = 1'b1;
                    job.tail_cp  = cont_pv;
                    st_next      = '0;
                end
                else if (final_byte)
                begin
                    job.rep_count = buf_inc + 2'd1;
                    st_next       = '0;
                end
                else
                begin
                    st_next.partial  = cont_pv;
                    st_next.need     = need_dec;
                    st_next.buffered = buf_inc;
                end
            end
            else
            begin
                job.rep_count = st.buffered + 2'd1;
                st_next       = '0;
                fresh         = 1'b1;
            end
        end
        else
        begin
            fresh = 1'b1;
        end

        // Decode the byte as the start of a new character
        if (fresh)
        begin
            if (data_byte == '0)
            begin
                nul_hit      = 1'b1;
                job.tail_vld = 1'b1;
            end
            else if (data_byte[7] == 1'b0)
            begin
                job.tail_vld = 1'b1;
                job.tail_cp  = {{(u8sd_pkg::CP_W-u8sd_pkg::BYTE_W){1'b0}}, data_byte};
            end
            else if (data_byte[7:5] == u8sd_pkg::LEAD2_TAG ||
                     data_byte[7:4] == u8sd_pkg::LEAD3_TAG ||
                     data_byte[7:3] == u8sd_pkg::LEAD4_TAG)
            begin
                if (final_byte)
                begin
                    job.tail_vld = 1'b1;
                    job.tail_cp  = u8sd_pkg::REPL_CP;
                    job.tail_bad = 1'b1;
                end
                else
                begin
                    st_next.buffered = 2'd0;
                    if (data_byte[7:5] == u8sd_pkg::LEAD2_TAG)
                    begin
                        st_next.partial = {{(u8sd_pkg::CP_W-5){1'b0}}, data_byte[4:0]};
                        st_next.need    = u8sd_pkg::NEED_ONE;
                    end
                    else if (data_byte[7:4] == u8sd_pkg::LEAD3_TAG)
                    begin
                        st_next.partial = {{(u8sd_pkg::CP_W-4){1'b0}}, data_byte[3:0]};
                        st_next.need    = u8sd_pkg::NEED_TWO;
                    end
                    else
                    begin
                        st_next.partial = {{(u8sd_pkg::CP_W-3){1'b0}}, data_byte[2:0]};
                        st_next.need    = u8sd_pkg::NEED_THREE;
                    end
                end
            end
            else
            begin
                job.tail_vld = 1'b1;
                job.tail_cp  = u8sd_pkg::REPL_CP;
                job.tail_bad = 1'b1;
            end
        end

        job.end_flag = final_byte | nul_hit;
    end

endmodule

/* sv/utf8_stream_decoder.sv */
// A byte's results pass through the job register and then the output register.
// Throughput: one byte per cycle while the sink is ready; a byte that causes n results
// holds the input while the result stage sends them one a cycle, unless the sink stalls.
// Bytes that only extend a pending sequence cause no result.
// Reset (rst_n low, asynchronous) clears the pending sequence and both valid flags.
module utf8_stream_decoder (
    input  logic          clk,
    input  logic          rst_n,
    u8sd_byte_if.sink     byte_ch,
    u8sd_cp_if.source     cp_ch
);

    u8sd_pkg::state_t           st_reg;
    u8sd_pkg::state_t           st_next;
    u8sd_pkg::job_t             dec_job;
    u8sd_pkg::job_t             job_reg;
    logic                       job_vld_reg;
    logic                       job_has_results;
    logic                       in_beat;
    logic                       job_adv;
    logic                       job_done;
    logic                       rep_active;
    logic                       cur_last;
    logic [u8sd_pkg::CP_W-1:0]  cur_cp;
    logic                       cur_bad;
    logic                       cur_end;
    logic                       out_vld_reg;
    logic [u8sd_pkg::CP_W-1:0]  cp_reg;
    logic                       bad_reg;
    logic                       end_reg;
    logic                       last_reg;

    u8sd_decode u_decode (
        .st         (st_reg),
        .data_byte  (byte_ch.data_byte),
        .final_byte (byte_ch.final_byte),
        .st_next    (st_next),
        .job        (dec_job)
    );

    // Pick the result the job register sends next
    assign rep_active = (job_reg.rep_count != 2'd0);
    assign cur_last   = rep_active ? (job_reg.rep_count == 2'd1 && !job_reg.tail_vld) : 1'b1;
    assign cur_cp     = rep_active ? u8sd_pkg::REPL_CP : job_reg.tail_cp;
    assign cur_bad    = rep_active | job_reg.tail_bad;
    assign cur_end    = cur_last & job_reg.end_flag;

    // Advance the job when the output register is free or being drained
    assign job_adv         = job_vld_reg && (!out_vld_reg || cp_ch.ready);
    assign job_done        = job_adv && cur_last;
    assign byte_ch.ready   = !job_vld_reg || job_done;
    assign in_beat         = byte_ch.valid && byte_ch.ready;
    assign job_has_results = (dec_job.rep_count != 2'd0) || dec_job.tail_vld;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            job_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                st_reg <= st_next;
            end
            if (in_beat)
            begin
                job_vld_reg <= job_has_results;
            end
            else if (job_done)
            begin
                job_vld_reg <= 1'b0;
            end
            if (job_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (cp_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Load a new job, or count down its replacement run
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            job_reg <= dec_job;
        end
        else if (job_adv && rep_active)
        begin
            job_reg.rep_count <= job_reg.rep_count - 2'd1;
        end
    end

    // Hold the result beat until the sink takes it
    always_ff @(posedge clk)
    begin
        if (job_adv)
        begin
            cp_reg   <= cur_cp;
            bad_reg  <= cur_bad;
            end_reg  <= cur_end;
            last_reg <= cur_last;
        end
    end

    assign cp_ch.valid      = out_vld_reg;
    assign cp_ch.code_point = cp_reg;
    assign cp_ch.malformed  = bad_reg;
    assign cp_ch.string_end = end_reg;
    assign cp_ch.run_last   = last_reg;

endmodule

/* sv/u8sd_checker.sv */
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [u8sd_pkg::CP_W-1:0]  code_point,
    input  logic                       malformed,
    input  logic                       string_end,
    input  logic                       run_last
);

    // A stalled result beat stays put
    `U8SD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(malformed) && $stable(string_end) && $stable(run_last), "result beat changed while stalled")

    // Every replacement carries U+FFFD
    `U8SD_ASSERT_NOW(a_repl, out_valid && malformed, code_point == u8sd_pkg::REPL_CP, "malformed beat without U+FFFD")

    // The end of a string is always the last result of its byte
    `U8SD_ASSERT_NOW(a_end_last, out_valid && string_end, run_last, "string end before last result of byte")

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (cp_ch.valid),
    .out_ready  (cp_ch.ready),
    .code_point (cp_ch.code_point),
    .malformed  (cp_ch.malformed),
    .string_end (cp_ch.string_end),
    .run_last   (cp_ch.run_last)
);
